### rtl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, constants and keyword tables for the markup tag to ANSI
// escape converter.
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int TAG_MAX   = 17;
    localparam int KEY_COUNT = 39;
    localparam int ESC_MAX   = 7;
    localparam int NAME_W    = 8 * TAG_MAX;
    localparam int SEQ_W     = 8 * ESC_MAX;
    localparam int TLEN_W    = $clog2(TAG_MAX + 1);
    localparam int KEY_W     = $clog2(KEY_COUNT);
    localparam int EIDX_W    = $clog2(ESC_MAX + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = QPTR_W + 1;
    localparam int EL_N      = 7;

    typedef logic [TLEN_W-1:0] tag_len_t;
    typedef logic [KEY_W-1:0]  key_idx_t;
    typedef logic [EIDX_W-1:0] esc_idx_t;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ONE,
        MODE_TWO,
        MODE_TAG
    } mode_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNCLOSED = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_NO_OPEN  = 3'd3;
    localparam logic [2:0] ST_OPEN_END = 3'd4;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam key_idx_t KEY_RESET = '0;

    // One command per transfer that produces results, in emission order:
    // held '[', text byte, escape sequence, tag error, unclosed, open at end,
    // silent end.
    typedef struct packed {
        logic       sil;
        logic       opn;
        logic       unc;
        logic       err;
        logic       esc;
        logic       txt;
        logic       lb;
        logic [7:0] data;
        key_idx_t   key;
        logic [2:0] code;
        logic       last;
    } mta_cmd_t;

    localparam logic [NAME_W-1:0] KEY_NAME [KEY_COUNT] = '{
        "/", "NUMBER", "BOLD", "DIM", "ITALIC", "UNDER", "STRIKE",
        "BLACK", "BRIGHT-BLACK", "ON BLACK", "ON BRIGHT-BLACK",
        "RED", "BRIGHT-RED", "ON RED", "ON BRIGHT-RED",
        "GREEN", "BRIGHT-GREEN", "ON GREEN", "ON BRIGHT-GREEN",
        "YELLOW", "BRIGHT-YELLOW", "ON YELLOW", "ON BRIGHT-YELLOW",
        "BLUE", "BRIGHT-BLUE", "ON BLUE", "ON BRIGHT-BLUE",
        "MAGENTA", "BRIGHT-MAGENTA", "ON MAGENTA", "ON BRIGHT-MAGENTA",
        "CYAN", "BRIGHT-CYAN", "ON CYAN", "ON BRIGHT-CYAN",
        "WHITE", "BRIGHT-WHITE", "ON WHITE", "ON BRIGHT-WHITE"
    };

    localparam logic [SEQ_W-1:0] KEY_SEQ [KEY_COUNT] = '{
        "\033[0m", "\033[1;36m", "\033[1m", "\033[2m", "\033[3m",
        "\033[4m", "\033[9m",
        "\033[30m", "\033[90m", "\033[40m", "\033[100m",
        "\033[31m", "\033[91m", "\033[41m", "\033[101m",
        "\033[32m", "\033[92m", "\033[42m", "\033[102m",
        "\033[33m", "\033[93m", "\033[43m", "\033[103m",
        "\033[34m", "\033[94m", "\033[44m", "\033[104m",
        "\033[35m", "\033[95m", "\033[45m", "\033[105m",
        "\033[36m", "\033[96m", "\033[46m", "\033[106m",
        "\033[37m", "\033[97m", "\033[47m", "\033[107m"
    };

    // Strings are right-justified and zero-padded, and hold no zero bytes.
    function automatic tag_len_t name_len(input key_idx_t k);
        tag_len_t n;
        n = '0;
        for (int i = 0; i < TAG_MAX; i++)
        begin
            if (KEY_NAME[k][i*8 +: 8] != 8'h00)
                n = n + 1'b1;
        end
        return n;
    endfunction

    function automatic logic [7:0] name_char(input key_idx_t k, input tag_len_t j);
        tag_len_t          p;
        logic [NAME_W-1:0] s;
        p = name_len(k) - 1'b1 - j;
        s = KEY_NAME[k] >> {p, 3'b000};
        return s[7:0];
    endfunction

    function automatic esc_idx_t esc_len(input key_idx_t k);
        esc_idx_t n;
        n = '0;
        for (int i = 0; i < ESC_MAX; i++)
        begin
            if (KEY_SEQ[k][i*8 +: 8] != 8'h00)
                n = n + 1'b1;
        end
        return n;
    endfunction

    function automatic logic [7:0] esc_byte(input key_idx_t k, input esc_idx_t i);
        esc_idx_t         p;
        logic [SEQ_W-1:0] s;
        p = esc_len(k) - 1'b1 - i;
        s = KEY_SEQ[k] >> {p, 3'b000};
        return s[7:0];
    endfunction

    function automatic logic [EL_N-1:0] cmd_mask(input mta_cmd_t c);
        return {c.sil, c.opn, c.unc, c.err, c.esc, c.txt, c.lb};
    endfunction

endpackage

### rtl/mta_front.sv
// ----------------------------------------------------------------------------
// mta_front
// Input parser: tracks bracket and tag state, matches keywords byte by byte
// and hands one command per producing transfer to the queue.
// ----------------------------------------------------------------------------
module mta_front
    import mta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic [7:0] in_byte,
    input  logic     in_last,
    input  logic     mono,
    input  logic     full,
    output logic     push,
    output mta_cmd_t cmd
);

    mode_t                mode_reg, mode_next, mode_step;
    tag_len_t             tag_len_reg, tag_len_next;
    logic                 ovf_reg, ovf_next;
    logic [KEY_COUNT-1:0] cand_reg, cand_next;
    logic                 style_reg, style_next, style_step;

    logic                 acc, is_open, is_close, enter_tag, tag_step, resolve;
    tag_len_t             base_len;
    logic                 base_ovf, found;
    logic [KEY_COUNT-1:0] base_cand, step_cand, hit;
    key_idx_t             found_key;

    assign in_stall  = full;
    assign acc       = in_valid && !full;
    assign is_open   = (in_byte == CH_OPEN);
    assign is_close  = (in_byte == CH_CLOSE);
    assign enter_tag = (mode_reg == MODE_ONE) && !in_last && !is_open;
    assign tag_step  = (mode_reg == MODE_TAG) || enter_tag;
    assign resolve   = tag_step && is_close;
    assign base_len  = enter_tag ? '0 : tag_len_reg;
    assign base_ovf  = enter_tag ? 1'b0 : ovf_reg;
    assign base_cand = enter_tag ? '1 : cand_reg;

    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            step_cand[k] = base_cand[k]
                && (base_len < name_len(KEY_W'(k)))
                && (name_char(KEY_W'(k), base_len) == in_byte);
            hit[k] = base_cand[k] && (name_len(KEY_W'(k)) == base_len);
        end
    end

    always_comb
    begin
        found_key = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
                found_key = KEY_W'(k);
        end
    end

    assign found = !base_ovf && (|hit);

    // next state
    always_comb
    begin
        mode_step = mode_reg;
        case (mode_reg)
            MODE_TEXT:
                if (is_open && !in_last)
                    mode_step = MODE_ONE;
            MODE_ONE:
                if (in_last)
                    mode_step = MODE_TEXT;
                else if (is_open)
                    mode_step = MODE_TWO;
                else
                    mode_step = is_close ? MODE_TEXT : MODE_TAG;
            MODE_TWO:
                mode_step = (is_open && !in_last) ? MODE_ONE : MODE_TEXT;
            MODE_TAG:
                mode_step = is_close ? MODE_TEXT : MODE_TAG;
            default:
                mode_step = MODE_TEXT;
        endcase
        mode_next = in_last ? MODE_TEXT : mode_step;
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        style_step = style_reg;
        cmd.data   = in_byte;
        cmd.last   = in_last;
        cmd.key    = found_key;
        case (mode_reg)
            MODE_TEXT:
                cmd.txt = !(is_open && !in_last);
            MODE_ONE:
            begin
                cmd.lb  = in_last;
                cmd.txt = in_last;
            end
            MODE_TWO:
            begin
                cmd.lb  = 1'b1;
                cmd.txt = !(is_open && !in_last);
            end
            default:
                cmd.txt = 1'b0;
        endcase
        if (resolve)
        begin
            if (!found)
            begin
                cmd.err  = 1'b1;
                cmd.code = ST_UNKNOWN;
            end
            else if (found_key == KEY_RESET)
            begin
                if (!style_reg)
                begin
                    cmd.err  = 1'b1;
                    cmd.code = ST_NO_OPEN;
                end
                else
                begin
                    style_step = 1'b0;
                    cmd.esc    = !mono;
                end
            end
            else
            begin
                style_step = 1'b1;
                cmd.esc    = !mono;
            end
        end
        cmd.unc = in_last && (mode_step == MODE_TAG);
        cmd.opn = in_last && style_step;
        cmd.sil = in_last && !(cmd.lb || cmd.txt || cmd.esc || cmd.err
                               || cmd.unc || cmd.opn);
        style_next = in_last ? 1'b0 : style_step;
        push = acc && (cmd.lb || cmd.txt || cmd.esc || cmd.err || in_last);
    end

    always_comb
    begin
        tag_len_next = tag_len_reg;
        ovf_next     = ovf_reg;
        cand_next    = cand_reg;
        if (resolve || in_last)
        begin
            tag_len_next = '0;
            ovf_next     = 1'b0;
        end
        else if (tag_step)
        begin
            if (base_len < TLEN_W'(TAG_MAX))
            begin
                tag_len_next = base_len + 1'b1;
                ovf_next     = base_ovf;
                cand_next    = step_cand;
            end
            else
            begin
                tag_len_next = base_len;
                ovf_next     = 1'b1;
                cand_next    = base_cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_TEXT;
            tag_len_reg <= '0;
            ovf_reg     <= 1'b0;
            cand_reg    <= '0;
            style_reg   <= 1'b0;
        end
        else if (acc)
        begin
            mode_reg    <= mode_next;
            tag_len_reg <= tag_len_next;
            ovf_reg     <= ovf_next;
            cand_reg    <= cand_next;
            style_reg   <= style_next;
        end
    end

endmodule

### rtl/mta_queue.sv
// ----------------------------------------------------------------------------
// mta_queue
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module mta_queue
    import mta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mta_cmd_t wdata,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output mta_cmd_t head
);

    mta_cmd_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/mta_back.sv
// ----------------------------------------------------------------------------
// mta_back
// Output sequencer: walks the head command one result per cycle into the
// output register while the receiver does not stall.
// ----------------------------------------------------------------------------
module mta_back
    import mta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  mta_cmd_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_end,
    output logic       message_end,
    output logic [2:0] status
);

    logic [EL_N-1:0] done_reg, pending, cur, rest;
    esc_idx_t        idx_reg;
    logic            load, el_fin, last_el;
    logic [7:0]      res_byte;
    logic [2:0]      res_status;

    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            byte_valid_reg, run_end_reg, message_end_reg;
    logic [2:0]      status_reg;

    assign pending = cmd_mask(head) & ~done_reg;
    assign cur     = pending & (~pending + 1'b1);
    assign rest    = pending & ~cur;
    assign el_fin  = !cur[2] || (idx_reg == esc_len(head.key) - 1'b1);
    assign last_el = el_fin && (rest == '0);
    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = load && last_el;

    always_comb
    begin
        res_byte   = 8'h00;
        res_status = ST_OK;
        if (cur[0])
            res_byte = CH_OPEN;
        else if (cur[1])
            res_byte = head.data;
        else if (cur[2])
            res_byte = esc_byte(head.key, idx_reg);
        else if (cur[3])
            res_status = head.code;
        else if (cur[4])
            res_status = ST_UNCLOSED;
        else if (cur[5])
            res_status = ST_OPEN_END;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= res_byte;
            byte_valid_reg  <= |cur[2:0];
            run_end_reg     <= last_el;
            message_end_reg <= last_el && head.last;
            status_reg      <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (load)
            begin
                if (last_el)
                begin
                    done_reg <= '0;
                    idx_reg  <= '0;
                end
                else if (el_fin)
                begin
                    done_reg <= done_reg | cur;
                    idx_reg  <= '0;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign run_end     = run_end_reg;
    assign message_end = message_end_reg;
    assign status      = status_reg;

endmodule

### rtl/markup_tag_to_ansi_escape_core.sv
// ----------------------------------------------------------------------------
// markup_tag_to_ansi_escape_core
// Converts bracketed colour tags in a byte stream into ANSI escape sequences.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and in_last; a transfer takes
// place when in_valid is high and in_stall is low. Output channel: out_valid/
// out_stall with out_byte, byte_valid, run_end, message_end and status.
// cfg_valid/cfg_ready/cfg_data writes the no-colour flag; cfg_ready is always
// high, and the flag should only be changed while the block is idle.
// Throughput: one input byte per cycle while the queue is not full, and one
// result per cycle while the receiver does not stall. A tag that expands to
// an escape of n bytes gives n output results; a four-entry command queue
// between parser and sequencer absorbs the burst, and in_stall rises only
// when that queue is full. A transfer writes its command into the queue,
// and the sequencer then loads its results from the queue head into the
// output register. Reset clears parser state, queue and the output valid
// flag; no-colour returns to 0. When the receiver stalls, the output
// register holds its result and the queue keeps filling until full, after
// which the input is stalled.
// ----------------------------------------------------------------------------
module markup_tag_to_ansi_escape_core
    import mta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_end,
    output logic       message_end,
    output logic [2:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic     mono_reg;
    logic     push, full, pop, head_valid;
    mta_cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mono_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mono_reg <= cfg_data;
    end

    mta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .mono     (mono_reg),
        .full     (full),
        .push     (push),
        .cmd      (push_cmd)
    );

    mta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wdata      (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_end     (run_end),
        .message_end (message_end),
        .status      (status)
    );

endmodule

### rtl/mta_checker.sv
// ----------------------------------------------------------------------------
// mta_checker
// Port-level checks on the converter's output stream.
// ----------------------------------------------------------------------------
module mta_checker
    import mta_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_end,
    input logic       message_end,
    input logic [2:0] status
);

    a_msg_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_end)
        else $error("message end without run end");

    a_status_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("status-only result carries a byte");

    a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == ST_OK && !message_end
                                    || status == ST_OK && message_end)
        else $error("byte result with error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
                                   && $stable(status) && $stable(run_end))
        else $error("stalled result changed");

endmodule

bind markup_tag_to_ansi_escape_core mta_checker u_mta_checker (.*);

### sim/markup_tag_to_ansi_escape_core_tb.sv
// ----------------------------------------------------------------------------
// markup_tag_to_ansi_escape_core_tb
// Self-checking bench for the markup tag to ANSI escape converter. Message
// bytes go in over the stall handshake. A predictor in the bench tracks
// parser state, open style and the no-colour flag, and queues the expected
// output bytes and status results for each transfer. Every output transfer
// is checked field by field against the oldest entry. Directed messages
// cover the bracket and error corners, random messages are built mostly
// from keyword tags, and a long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module markup_tag_to_ansi_escape_core_tb;
    import mta_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       msg_end;
        logic [2:0] code;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       message_end;
    logic [2:0] status;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    markup_tag_to_ansi_escape_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_end     (run_end),
        .message_end (message_end),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    string kw_names [KEY_COUNT] = '{
        "/", "NUMBER", "BOLD", "DIM", "ITALIC", "UNDER", "STRIKE",
        "BLACK", "BRIGHT-BLACK", "ON BLACK", "ON BRIGHT-BLACK",
        "RED", "BRIGHT-RED", "ON RED", "ON BRIGHT-RED",
        "GREEN", "BRIGHT-GREEN", "ON GREEN", "ON BRIGHT-GREEN",
        "YELLOW", "BRIGHT-YELLOW", "ON YELLOW", "ON BRIGHT-YELLOW",
        "BLUE", "BRIGHT-BLUE", "ON BLUE", "ON BRIGHT-BLUE",
        "MAGENTA", "BRIGHT-MAGENTA", "ON MAGENTA", "ON BRIGHT-MAGENTA",
        "CYAN", "BRIGHT-CYAN", "ON CYAN", "ON BRIGHT-CYAN",
        "WHITE", "BRIGHT-WHITE", "ON WHITE", "ON BRIGHT-WHITE"
    };

    string kw_seqs [KEY_COUNT] = '{
        "\033[0m", "\033[1;36m", "\033[1m", "\033[2m", "\033[3m",
        "\033[4m", "\033[9m",
        "\033[30m", "\033[90m", "\033[40m", "\033[100m",
        "\033[31m", "\033[91m", "\033[41m", "\033[101m",
        "\033[32m", "\033[92m", "\033[42m", "\033[102m",
        "\033[33m", "\033[93m", "\033[43m", "\033[103m",
        "\033[34m", "\033[94m", "\033[44m", "\033[104m",
        "\033[35m", "\033[95m", "\033[45m", "\033[105m",
        "\033[36m", "\033[96m", "\033[46m", "\033[106m",
        "\033[37m", "\033[97m", "\033[47m", "\033[107m"
    };

    // predictor state
    mode_t      pmode;
    logic [7:0] tag_chars [TAG_MAX];
    int         tag_len;
    bit         tag_ovf;
    bit         style_on;
    bit         plain_mode;

    result_t    step_out [$];
    result_t    expected_results [$];
    logic [7:0] msg_bytes [$];

    int fail_count;
    int items_sent;
    int kw_turn;
    int in_idle_pct;
    int out_stall_pct;
    int hold_request;
    int hold_left;

    always #2 clk = ~clk;

    function automatic void emit(input logic [7:0] d, input logic hb, input logic [2:0] c);
        result_t r;
        r.data     = d;
        r.has_byte = hb;
        r.run_end  = 1'b0;
        r.msg_end  = 1'b0;
        r.code     = c;
        if (step_out.size() < 8)
            step_out.push_back(r);
    endfunction

    function automatic void text_in(input logic [7:0] b, input bit last);
        if (b == CH_OPEN && !last)
            pmode = MODE_ONE;
        else
            emit(b, 1'b1, ST_OK);
    endfunction

    function automatic void close_tag();
        int    found;
        bit    same;
        string nm;
        found = -1;
        pmode = MODE_TEXT;
        if (!tag_ovf)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                nm = kw_names[k];
                if (found < 0 && nm.len() == tag_len)
                begin
                    same = 1'b1;
                    for (int i = 0; i < tag_len; i++)
                        if (nm[i] != tag_chars[i])
                            same = 1'b0;
                    if (same)
                        found = k;
                end
            end
        end
        tag_len = 0;
        tag_ovf = 1'b0;
        if (found < 0)
            emit(8'h00, 1'b0, ST_UNKNOWN);
        else if (found == 0 && !style_on)
            emit(8'h00, 1'b0, ST_NO_OPEN);
        else
        begin
            style_on = (found != 0);
            if (!plain_mode)
            begin
                nm = kw_seqs[found];
                for (int i = 0; i < nm.len(); i++)
                    emit(nm[i], 1'b1, ST_OK);
            end
        end
    endfunction

    function automatic void tag_in(input logic [7:0] b);
        if (b == CH_CLOSE)
            close_tag();
        else if (tag_len < TAG_MAX)
        begin
            tag_chars[tag_len] = b;
            tag_len++;
        end
        else
            tag_ovf = 1'b1;
    endfunction

    function automatic void predict_escape_output(input logic [7:0] b, input bit last);
        step_out.delete();
        case (pmode)
            MODE_TEXT:
                text_in(b, last);
            MODE_ONE:
                if (last)
                begin
                    pmode = MODE_TEXT;
                    emit(CH_OPEN, 1'b1, ST_OK);
                    emit(b, 1'b1, ST_OK);
                end
                else if (b == CH_OPEN)
                    pmode = MODE_TWO;
                else
                begin
                    pmode   = MODE_TAG;
                    tag_len = 0;
                    tag_ovf = 1'b0;
                    tag_in(b);
                end
            MODE_TWO:
            begin
                pmode = MODE_TEXT;
                emit(CH_OPEN, 1'b1, ST_OK);
                text_in(b, last);
            end
            default:
                tag_in(b);
        endcase
        if (last)
        begin
            if (pmode == MODE_TAG)
                emit(8'h00, 1'b0, ST_UNCLOSED);
            if (style_on)
                emit(8'h00, 1'b0, ST_OPEN_END);
            if (step_out.size() == 0)
                emit(8'h00, 1'b0, ST_OK);
            pmode    = MODE_TEXT;
            tag_len  = 0;
            tag_ovf  = 1'b0;
            style_on = 1'b0;
        end
        if (step_out.size() > 0)
        begin
            step_out[step_out.size()-1].run_end = 1'b1;
            step_out[step_out.size()-1].msg_end = last;
        end
        foreach (step_out[i])
            expected_results.push_back(step_out[i]);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                plain_mode = cfg_data;
            if (in_valid && !in_stall)
                predict_escape_output(in_byte, in_last);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual byte %0h status %0d",
                             $time, out_byte, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.data, out_byte);
                    check_field("byte_valid", 8'(want.has_byte), 8'(byte_valid));
                    check_field("run_end", 8'(want.run_end), 8'(run_end));
                    check_field("message_end", 8'(want.msg_end), 8'(message_end));
                    check_field("status", 8'(want.code), 8'(status));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < in_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while ($urandom_range(99) < in_idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_no_colour(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endfunction

    function automatic void add_letters(input int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(9))
                0:       msg_bytes.push_back("-");
                1:       msg_bytes.push_back(" ");
                default: msg_bytes.push_back(8'($urandom_range(65, 90)));
            endcase
    endfunction

    function automatic void add_tag(input string s);
        msg_bytes.push_back(CH_OPEN);
        add_str(s);
        msg_bytes.push_back(CH_CLOSE);
    endfunction

    // mostly tag-rich messages, with some pure noise
    function automatic void build_random_message();
        int    w;
        string nm;
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 8))
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 6))
        begin
            w = $urandom_range(99);
            if (w < 45)
            begin
                add_tag(kw_names[kw_turn % KEY_COUNT]);
                kw_turn++;
            end
            else if (w < 55)
                add_tag("/");
            else if (w < 75)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            else if (w < 80)
                add_str("[[");
            else if (w < 90)
            begin
                msg_bytes.push_back(CH_OPEN);
                add_letters($urandom_range(0, 5));
                msg_bytes.push_back(CH_CLOSE);
            end
            else if (w < 94)
            begin
                msg_bytes.push_back(CH_OPEN);
                add_letters($urandom_range(16, 20));
                msg_bytes.push_back(CH_CLOSE);
            end
            else
            begin
                nm = kw_names[$urandom_range(1, KEY_COUNT - 1)];
                add_tag(nm.substr(0, nm.len() - 2));
            end
        end
        w = $urandom_range(99);
        if (w < 8)
        begin
            msg_bytes.push_back(CH_OPEN);
            add_letters($urandom_range(1, 3));
        end
        else if (w < 13)
            msg_bytes.push_back(CH_OPEN);
    endfunction

    task automatic test_directed_colour();
        set_no_colour(1'b0);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(CH_OPEN);
        send_msg();
        add_str("[[[a");
        send_msg();
        add_str("[][/]");
        send_msg();
        add_str("[DIM][AB");
        send_msg();
        wait_for_results();
    endtask

    task automatic test_directed_no_colour();
        set_no_colour(1'b1);
        add_str("[RED][/]");
        send_msg();
        wait_for_results();
    endtask

    task automatic test_random_messages(input int n, input logic nc, input int in_pct,
                                        input int out_pct);
        int start;
        set_no_colour(nc);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start = items_sent;
        while (items_sent - start < n)
        begin
            build_random_message();
            send_msg();
        end
        wait_for_results();
    endtask

    task automatic test_output_hold_off();
        set_no_colour(1'b0);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_request  = 60;
        add_str("[NUMBER]x[ON BRIGHT-WHITE]y[/]end");
        send_msg();
        wait_for_results();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        in_last       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        out_stall     = 1'b0;
        pmode         = MODE_TEXT;
        tag_len       = 0;
        tag_ovf       = 1'b0;
        style_on      = 1'b0;
        plain_mode    = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        kw_turn       = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_request  = 0;
        hold_left     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_colour();
        test_directed_no_colour();
        test_random_messages(70, 1'b0, 9, 79);
        test_random_messages(70, 1'b1, 79, 9);
        test_random_messages(70, 1'b0, 0, 0);
        test_output_hold_off();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
